// File: hw/rtl/swrt_pkg.sv
// Shared types and constants for the sliding window retransmit table.
// Used by swrt_slot_eval, sliding_window_retransmit_table_unit and the testbench; no dependencies.
package swrt_pkg;

    localparam int KIND_W    = 4;
    localparam int SLOT_W    = 5;
    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 7;
    localparam int PAYLOAD_W = 7;
    localparam int WIN_W     = 6;
    localparam int RELOAD_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam int SEG_HDR   = 24;
    localparam int LEN_MAX   = 127;

    localparam logic [WIN_W-1:0]    WINDOW_RESET = 6'd20;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_RELOAD = 1'd1;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_DATA = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SENT        = 4'd0;
    localparam logic [KIND_W-1:0] KIND_WINDOW_FULL = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ACK_MATCH   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ACK_NONE    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RESEND      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RELEASED    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DELIVER     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_OUT_OF_ORD  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_TICK_IDLE   = 4'd8;

    // Decision for the slot under the scan pointer.
    typedef struct packed {
        logic              claim;     // send takes this free slot
        logic              hit;       // slot produces an ack, release or resend result
        logic              set_ack;
        logic              release_slot;
        logic              reload;
        logic              dec;
        logic [KIND_W-1:0] kind;
    } t_slot_act;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
    } t_result;

endpackage

// File: hw/rtl/swrt_slot_eval.sv
// Per-slot decision unit: compares one slot's state against the current command.
// Depends on swrt_pkg.
module swrt_slot_eval (
    input  logic [1:0]                 i_cmd,
    input  logic                       i_busy,
    input  logic                       i_acked,
    input  logic [swrt_pkg::RELOAD_W-1:0] i_timer,
    input  logic [swrt_pkg::SEQ_W-1:0] i_slot_seq,
    input  logic [swrt_pkg::SEQ_W-1:0] i_seq_in,
    output swrt_pkg::t_slot_act        o_act
);
    import swrt_pkg::*;

    always_comb begin
        o_act = '0;
        case (i_cmd)
            CMD_SEND: begin
                o_act.claim = !i_busy;
                o_act.kind  = KIND_SENT;
            end
            CMD_ACK: begin
                if (i_busy && (i_slot_seq == i_seq_in)) begin
                    o_act.hit     = 1'b1;
                    o_act.set_ack = 1'b1;
                end
                o_act.kind = KIND_ACK_MATCH;
            end
            CMD_TICK: begin
                if (i_busy) begin
                    if (i_acked) begin
                        o_act.hit          = 1'b1;
                        o_act.release_slot = 1'b1;
                        o_act.kind         = KIND_RELEASED;
                    end else if (i_timer == '0) begin
                        o_act.hit    = 1'b1;
                        o_act.reload = 1'b1;
                        o_act.kind   = KIND_RESEND;
                    end else begin
                        o_act.dec = 1'b1;
                    end
                end
            end
            default: begin
                o_act = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/sliding_window_retransmit_table_unit.sv
// Top level of the sliding window retransmit table: slot state, scan sequencer
// and output register. Depends on swrt_pkg and swrt_slot_eval.
//
// One transaction at a time. A send, ack or tick walks the active slots one per
// cycle through a single slot evaluation unit, pausing as described below. The
// active count is window_size limited to MAX_SLOTS. A send that claims slot k
// stops there, and a data segment skips the walk. Each result found during the
// walk is held in a pending register so the final one can carry last. When the
// output register is not drained, the walk pauses on a slot that has a result,
// and the final result waits for room; both add cycles. Configuration writes are
// always accepted and must only be issued while the block is idle. No clearing
// pass after reset is needed.
module sliding_window_retransmit_table_unit #(
    parameter int MAX_SLOTS   = 32,
    parameter int MAX_PAYLOAD = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swrt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swrt_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [swrt_pkg::SEQ_W-1:0]        i_seq_num,
    input  logic [swrt_pkg::PAYLOAD_W-1:0]    i_payload_len,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [swrt_pkg::KIND_W-1:0]       o_kind,
    output logic [swrt_pkg::SLOT_W-1:0]       o_slot,
    output logic [swrt_pkg::SEQ_W-1:0]        o_seq_out,
    output logic [swrt_pkg::LEN_W-1:0]        o_seg_len,
    output logic                              o_last
);
    import swrt_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Configuration.
    logic [WIN_W-1:0]    r_window;
    logic [RELOAD_W-1:0] r_reload;

    // Slot table.
    logic                r_busy  [MAX_SLOTS];
    logic                r_acked [MAX_SLOTS];
    logic [RELOAD_W-1:0] r_timer [MAX_SLOTS];
    logic [SEQ_W-1:0]    r_sseq  [MAX_SLOTS];
    logic [LEN_W-1:0]    r_slen  [MAX_SLOTS];

    logic [SEQ_W-1:0] r_next_send, n_next_send;
    logic [SEQ_W-1:0] r_next_exp,  n_next_exp;

    // Sequencer and latched transaction.
    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_idx,   n_idx;
    logic [1:0]       r_cmd,   n_cmd;
    logic [SEQ_W-1:0] r_seq,   n_seq;
    logic [PAYLOAD_W-1:0] r_pl, n_pl;
    logic [LEN_W-1:0] r_seglen, n_seglen;
    logic             r_pend_valid, n_pend_valid;
    t_result          r_pend, n_pend;

    // Output register.
    logic             r_out_valid;
    t_result          r_out;
    logic             r_out_last;

    logic [PAYLOAD_W-1:0] pl_clamp;
    logic [LEN_W:0]       seg_sum;
    logic [LEN_W-1:0]     seg_len_in;
    logic [CW-1:0]        n_active;
    logic [SW-1:0]        slot_ix;
    logic [31:0]          idx_wide;
    logic [SLOT_W-1:0]    slot5;
    t_slot_act            act;
    logic                 out_free;
    logic                 in_take;
    logic                 scan_live;
    logic                 stall;
    logic                 commit;
    logic                 push;
    logic                 push_last;
    t_result              push_res;
    t_result              slot_res;

    always_comb begin
        pl_clamp = i_payload_len;
        if (int'(i_payload_len) > MAX_PAYLOAD) begin
            pl_clamp = PAYLOAD_W'(MAX_PAYLOAD);
        end
        seg_sum = {1'b0, pl_clamp} + (LEN_W + 1)'(SEG_HDR);
        seg_len_in = (int'(seg_sum) > LEN_MAX) ? LEN_W'(LEN_MAX) : seg_sum[LEN_W-1:0];
    end

    always_comb begin
        if (int'(r_window) > MAX_SLOTS) begin
            n_active = CW'(MAX_SLOTS);
        end else begin
            n_active = CW'(r_window);
        end
    end

    assign slot_ix  = r_idx[SW-1:0];
    assign idx_wide = 32'(r_idx);
    assign slot5    = idx_wide[SLOT_W-1:0];

    swrt_slot_eval u_eval (
        .i_cmd      (r_cmd),
        .i_busy     (r_busy[slot_ix]),
        .i_acked    (r_acked[slot_ix]),
        .i_timer    (r_timer[slot_ix]),
        .i_slot_seq (r_sseq[slot_ix]),
        .i_seq_in   (r_seq),
        .o_act      (act)
    );

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_take   = i_in_valid && (r_state == ST_IDLE);
    assign scan_live = (r_state == ST_SCAN) && (r_idx < n_active);
    // A new result must first push the held one out.
    assign stall     = act.hit && r_pend_valid && !out_free;
    assign commit    = scan_live && !stall;

    always_comb begin
        slot_res.kind = act.kind;
        slot_res.slot = slot5;
        slot_res.seq  = r_sseq[slot_ix];
        slot_res.len  = r_slen[slot_ix];
        if (act.claim) begin
            slot_res.seq = r_next_send;
            slot_res.len = r_seglen;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_seq        = r_seq;
        n_pl         = r_pl;
        n_seglen     = r_seglen;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_next_send  = r_next_send;
        n_next_exp   = r_next_exp;
        push         = 1'b0;
        push_last    = 1'b0;
        push_res     = r_pend;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_cmd        = i_cmd;
                    n_seq        = i_seq_num;
                    n_pl         = pl_clamp;
                    n_seglen     = seg_len_in;
                    n_idx        = '0;
                    n_pend_valid = 1'b0;
                    n_pend       = '0;
                    n_state      = ST_SCAN;
                    case (i_cmd)
                        CMD_SEND: begin
                            n_pend.kind = KIND_WINDOW_FULL;
                            n_pend.seq  = r_next_send;
                            n_pend.len  = seg_len_in;
                        end
                        CMD_ACK: begin
                            n_pend.kind = KIND_ACK_NONE;
                            n_pend.seq  = i_seq_num;
                        end
                        CMD_TICK: begin
                            n_pend.kind = KIND_TICK_IDLE;
                        end
                        default: begin
                            n_pend.seq = i_seq_num;
                            n_pend.len = seg_len_in;
                            n_state    = ST_FINISH;
                            if (i_seq_num == r_next_exp) begin
                                n_pend.kind = KIND_DELIVER;
                                n_next_exp  = r_next_exp + SEQ_W'(pl_clamp);
                            end else begin
                                n_pend.kind = KIND_OUT_OF_ORD;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!scan_live) begin
                    n_state = ST_FINISH;
                end else if (act.claim) begin
                    n_pend      = slot_res;
                    n_next_send = r_next_send + SEQ_W'(r_pl);
                    n_state     = ST_FINISH;
                end else if (!stall) begin
                    if (act.hit) begin
                        push         = r_pend_valid;
                        n_pend       = slot_res;
                        n_pend_valid = 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_next_send  <= '0;
            r_next_exp   <= '0;
            r_out_valid  <= 1'b0;
            r_window     <= WINDOW_RESET;
            r_reload     <= RELOAD_RESET;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_next_send  <= n_next_send;
            r_next_exp   <= n_next_exp;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE:  r_window <= i_cfg_data[WIN_W-1:0];
                    CFG_RETRY_RELOAD: r_reload <= i_cfg_data[RELOAD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_seq    <= n_seq;
        r_pl     <= n_pl;
        r_seglen <= n_seglen;
        r_pend   <= n_pend;
        if (push) begin
            r_out      <= push_res;
            r_out_last <= push_last;
        end
    end

    // Slot flags and timers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_busy[k]  <= 1'b0;
                r_acked[k] <= 1'b0;
                r_timer[k] <= '0;
            end
        end else if (commit) begin
            if (act.claim) begin
                r_busy[slot_ix]  <= 1'b1;
                r_acked[slot_ix] <= 1'b0;
                r_timer[slot_ix] <= r_reload;
            end
            if (act.set_ack) begin
                r_acked[slot_ix] <= 1'b1;
            end
            if (act.release_slot) begin
                r_busy[slot_ix]  <= 1'b0;
                r_acked[slot_ix] <= 1'b0;
                r_timer[slot_ix] <= '0;
            end
            if (act.reload) begin
                r_timer[slot_ix] <= r_reload;
            end
            if (act.dec) begin
                r_timer[slot_ix] <= r_timer[slot_ix] - 1'b1;
            end
        end
    end

    // Stored sequence and length, written only when a send claims the slot.
    always_ff @(posedge i_clk) begin
        if (commit && act.claim) begin
            r_sseq[slot_ix] <= r_next_send;
            r_slen[slot_ix] <= r_seglen;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_slot      = r_out.slot;
    assign o_seq_out   = r_out.seq;
    assign o_seg_len   = r_out.len;
    assign o_last      = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held result left over while idle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= n_active))
        else $error("scan pointer ran past the active window");

    a_finish_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && out_free) |=> (o_out_valid && o_last))
        else $error("final result not presented with last");

    a_take_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("accepted transaction did not start work");

endmodule

// File: test/swrt_table_monitor.sv
// Monitor for the sliding window retransmit table: predicts the results of each
// accepted transaction and compares them with the block's results in order.
// Depends on swrt_pkg.
module swrt_table_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [swrt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swrt_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [swrt_pkg::SEQ_W-1:0]     i_seq_num,
    input  logic [swrt_pkg::PAYLOAD_W-1:0] i_payload_len,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [swrt_pkg::KIND_W-1:0]    i_kind,
    input  logic [swrt_pkg::SLOT_W-1:0]    i_slot,
    input  logic [swrt_pkg::SEQ_W-1:0]     i_seq_out,
    input  logic [swrt_pkg::LEN_W-1:0]     i_seg_len,
    input  logic                           i_last,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import swrt_pkg::*;

    localparam int NUM_SLOTS   = 1 << SLOT_W;
    localparam int PAYLOAD_CAP = 100;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_expect;

    logic [WIN_W-1:0]    cfg_window;
    logic [RELOAD_W-1:0] cfg_reload;
    logic                occupied   [NUM_SLOTS];
    logic                ack_seen   [NUM_SLOTS];
    logic [RELOAD_W-1:0] countdown  [NUM_SLOTS];
    logic [SEQ_W-1:0]    stored_seq [NUM_SLOTS];
    logic [LEN_W-1:0]    stored_len [NUM_SLOTS];
    logic [SEQ_W-1:0]    tx_seq;
    logic [SEQ_W-1:0]    rx_seq;

    t_expect pending_results[$];
    int      fail_count = 0;
    int      awaiting   = 0;

    assign o_errors  = fail_count;
    assign o_pending = awaiting;

    // Header bytes are added to the payload; the sum saturates at the field width.
    function automatic logic [LEN_W-1:0] frame_len(input logic [PAYLOAD_W-1:0] pl);
        int total;
        total = int'(pl) + SEG_HDR;
        return (total > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(total);
    endfunction

    task automatic clear_state();
        cfg_window = WINDOW_RESET;
        cfg_reload = RELOAD_RESET;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            occupied[s]   = 1'b0;
            ack_seen[s]   = 1'b0;
            countdown[s]  = '0;
            stored_seq[s] = '0;
            stored_len[s] = '0;
        end
        tx_seq = '0;
        rx_seq = '0;
        pending_results.delete();
    endtask

    task automatic apply_command(input logic [1:0] cmd, input logic [SEQ_W-1:0] seq,
                                 input logic [PAYLOAD_W-1:0] raw_len);
        t_result              found[$];
        logic [PAYLOAD_W-1:0] pl;
        int                   active;
        int                   idx;
        pl = (raw_len > PAYLOAD_CAP) ? PAYLOAD_W'(PAYLOAD_CAP) : raw_len;
        active = (int'(cfg_window) > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_window);
        case (cmd)
            CMD_SEND: begin
                idx = 0;
                while (idx < active && occupied[idx]) idx++;
                if (idx < active) begin
                    occupied[idx]   = 1'b1;
                    ack_seen[idx]   = 1'b0;
                    countdown[idx]  = cfg_reload;
                    stored_seq[idx] = tx_seq;
                    stored_len[idx] = frame_len(pl);
                    found.push_back('{kind: KIND_SENT, slot: SLOT_W'(idx),
                                      seq: tx_seq, len: stored_len[idx]});
                    tx_seq = tx_seq + SEQ_W'(pl);
                end else begin
                    found.push_back('{kind: KIND_WINDOW_FULL, slot: SLOT_W'(0),
                                      seq: tx_seq, len: frame_len(pl)});
                end
            end
            CMD_ACK: begin
                for (idx = 0; idx < active; idx++) begin
                    if (occupied[idx] && stored_seq[idx] == seq) begin
                        ack_seen[idx] = 1'b1;
                        found.push_back('{kind: KIND_ACK_MATCH, slot: SLOT_W'(idx),
                                          seq: stored_seq[idx], len: stored_len[idx]});
                    end
                end
                if (found.size() == 0)
                    found.push_back('{kind: KIND_ACK_NONE, slot: SLOT_W'(0),
                                      seq: seq, len: LEN_W'(0)});
            end
            CMD_TICK: begin
                for (idx = 0; idx < active; idx++) begin
                    if (occupied[idx]) begin
                        if (ack_seen[idx]) begin
                            found.push_back('{kind: KIND_RELEASED, slot: SLOT_W'(idx),
                                              seq: stored_seq[idx], len: stored_len[idx]});
                            occupied[idx]  = 1'b0;
                            ack_seen[idx]  = 1'b0;
                            countdown[idx] = '0;
                        end else if (countdown[idx] == 0) begin
                            found.push_back('{kind: KIND_RESEND, slot: SLOT_W'(idx),
                                              seq: stored_seq[idx], len: stored_len[idx]});
                            countdown[idx] = cfg_reload;
                        end else begin
                            countdown[idx] = countdown[idx] - 1'b1;
                        end
                    end
                end
                if (found.size() == 0)
                    found.push_back('{kind: KIND_TICK_IDLE, slot: SLOT_W'(0),
                                      seq: SEQ_W'(0), len: LEN_W'(0)});
            end
            CMD_DATA: begin
                if (seq == rx_seq) begin
                    found.push_back('{kind: KIND_DELIVER, slot: SLOT_W'(0),
                                      seq: seq, len: frame_len(pl)});
                    rx_seq = rx_seq + SEQ_W'(pl);
                end else begin
                    found.push_back('{kind: KIND_OUT_OF_ORD, slot: SLOT_W'(0),
                                      seq: seq, len: frame_len(pl)});
                end
            end
            default: begin
            end
        endcase
        foreach (found[j])
            pending_results.push_back('{res: found[j], last: (j == found.size() - 1)});
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Sampling at the falling edge sees the values that the next rising edge acts on.
    always @(negedge i_clk) begin
        t_expect want;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d slot %0d seq %0d", i_kind, i_slot,
                           i_seq_out);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.res.kind), 32'(i_kind));
                    check_field("slot", 32'(want.res.slot), 32'(i_slot));
                    check_field("seq_out", want.res.seq, i_seq_out);
                    check_field("seg_len", 32'(want.res.len), 32'(i_seg_len));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WINDOW_SIZE)
                    cfg_window = i_cfg_data[WIN_W-1:0];
                else if (i_cfg_index == CFG_RETRY_RELOAD)
                    cfg_reload = i_cfg_data[RELOAD_W-1:0];
            end
            if (i_in_valid && i_in_ready)
                apply_command(i_cmd, i_seq_num, i_payload_len);
        end
        awaiting = pending_results.size();
    end

endmodule

// File: test/tb.sv
// Top of the sliding window retransmit table testbench: clock, reset, stimulus
// and verdict. Depends on swrt_pkg, swrt_table_monitor and the block itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swrt_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 75;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RING_DEPTH   = 16;
    localparam int SETTLE       = 40;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_WINDOW_SIZE;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [1:0]           i_cmd         = CMD_TICK;
    logic [SEQ_W-1:0]     i_seq_num     = '0;
    logic [PAYLOAD_W-1:0] i_payload_len = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [SLOT_W-1:0]    o_slot;
    logic [SEQ_W-1:0]     o_seq_out;
    logic [LEN_W-1:0]     o_seg_len;
    logic                 o_last;

    int error_count;
    int results_due;

    int               items_issued  = 0;
    int               send_gap_pct  = 22;
    int               recv_gap_pct  = 83;
    int               hold_left     = 0;
    logic             hold_done     = 1'b0;
    int               cycle_count   = 0;
    logic [SEQ_W-1:0] rx_next       = '0;
    logic [SEQ_W-1:0] sent_ring [RING_DEPTH];
    int               sent_count    = 0;

    logic [CFG_DAT_W-1:0] phase_window [NUM_PHASES] =
        '{8'h20, 8'h41, 8'hC0, 8'hFF, 8'h83, 8'h0D};
    logic [CFG_DAT_W-1:0] phase_reload [NUM_PHASES] =
        '{8'h00, 8'hFF, 8'h01, 8'h00, 8'h02, 8'h07};

    sliding_window_retransmit_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_seq_num     (i_seq_num),
        .i_payload_len (i_payload_len),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_slot        (o_slot),
        .o_seq_out     (o_seq_out),
        .o_seg_len     (o_seg_len),
        .o_last        (o_last)
    );

    swrt_table_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_seq_num     (i_seq_num),
        .i_payload_len (i_payload_len),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_kind        (o_kind),
        .i_slot        (o_slot),
        .i_seq_out     (o_seq_out),
        .i_seg_len     (o_seg_len),
        .i_last        (o_last),
        .o_errors      (error_count),
        .o_pending     (results_due)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sliding_window_retransmit_table_unit test failed");
            $finish;
        end
    end

    // Once, the result side stops draining for a long stretch so the block backs up
    // and refuses new transactions while the sender keeps offering them.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && items_issued >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Sequences handed out by the block feed the acks of the random part.
    always @(negedge i_clk) begin
        if (o_out_valid && i_out_ready && o_kind == KIND_SENT) begin
            sent_ring[sent_count % RING_DEPTH] = o_seq_out;
            sent_count++;
        end
    end

    task automatic issue(input logic [1:0] cmd, input logic [SEQ_W-1:0] seq,
                         input logic [PAYLOAD_W-1:0] len);
        logic taken;
        if (items_issued < 160) begin
            send_gap_pct = 22;
            recv_gap_pct = 83;
        end else if (items_issued < 320) begin
            send_gap_pct = 83;
            recv_gap_pct = 22;
        end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
        end
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_seq_num     <= seq;
        i_payload_len <= len;
        if (cmd == CMD_DATA && seq == rx_next)
            rx_next = rx_next + ((len > 100) ? SEQ_W'(100) : SEQ_W'(len));
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        items_issued++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (results_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic program_table(input logic [CFG_DAT_W-1:0] window_data,
                                 input logic [CFG_DAT_W-1:0] reload_data);
        write_reg(CFG_WINDOW_SIZE, window_data);
        write_reg(CFG_RETRY_RELOAD, reload_data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_command();
        int                   pick;
        int                   known;
        logic [SEQ_W-1:0]     seq;
        logic [PAYLOAD_W-1:0] len;
        pick = $urandom_range(99);
        if ($urandom_range(7) == 0)
            len = PAYLOAD_W'($urandom_range(127));
        else
            len = PAYLOAD_W'($urandom_range(100));
        if (pick < 35) begin
            issue(CMD_SEND, $urandom, len);
        end else if (pick < 60) begin
            known = (sent_count < RING_DEPTH) ? sent_count : RING_DEPTH;
            if (known != 0 && $urandom_range(4) != 0)
                seq = sent_ring[$urandom_range(known - 1)];
            else
                seq = $urandom;
            issue(CMD_ACK, seq, len);
        end else if (pick < 80) begin
            issue(CMD_TICK, $urandom, len);
        end else begin
            case ($urandom_range(5))
                0:       seq = $urandom;
                1:       seq = rx_next + 1;
                default: seq = rx_next;
            endcase
            issue(CMD_DATA, seq, len);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty table, receive path, duplicate sequences from zero
        // length sends, repeated acks, release, countdown and a resend on expiry.
        issue(CMD_TICK, 32'hFFFF_FFFF, 7'd127);
        issue(CMD_ACK,  32'd0,         7'd0);
        issue(CMD_DATA, 32'd0,         7'd0);
        issue(CMD_DATA, 32'd0,         7'd127);
        issue(CMD_DATA, 32'd5,         7'd3);
        issue(CMD_DATA, 32'd100,       7'd100);
        issue(CMD_SEND, 32'd0,         7'd0);
        issue(CMD_SEND, 32'hFFFF_FFFF, 7'd0);
        issue(CMD_SEND, 32'd0,         7'd100);
        issue(CMD_SEND, 32'd0,         7'd127);
        issue(CMD_SEND, 32'd0,         7'd1);
        issue(CMD_ACK,  32'd0,         7'd0);
        issue(CMD_ACK,  32'd0,         7'd127);
        issue(CMD_ACK,  32'hFFFF_FFFF, 7'd0);
        issue(CMD_ACK,  32'd100,       7'd0);
        repeat (6) issue(CMD_TICK, 32'd0, 7'd0);
        issue(CMD_SEND, 32'd0,         7'd50);
        issue(CMD_DATA, 32'hFFFF_FFFF, 7'd100);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_table(phase_window[p], phase_reload[p]);
            repeat (PHASE_ITEMS) random_command();
            wait_idle();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("sliding_window_retransmit_table_unit test passed");
        else
            $display("sliding_window_retransmit_table_unit test failed");
        $finish;
    end

endmodule
